/* rtl/dsbc_pkg.sv */
// ----------------------------------------------------------------------------
// Draw state bucket census package
// Sizes, result codes and the beat types shared by the census chain and the
// top level.
// ----------------------------------------------------------------------------
package dsbc_pkg;

    // Number of buckets, one cell each.
    localparam int BUCKETS = 96;

    localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W   = $clog2(BUCKETS + 1);

    localparam int KEY_W   = 40;
    localparam int VCNT_W  = 31;
    localparam int DRAW_W  = 32;
    localparam int VSUM_W  = 48;
    localparam int OVF_W   = 32;
    localparam int SLOT_W  = 7;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index taken from paddr[PADDR_W-1:2].
    localparam logic [PADDR_W-3:0] REG_ENABLE = '0;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_NEW  = 2'd1,
        ST_FULL = 2'd2,
        ST_OFF  = 2'd3
    } t_status;

    // Lookup token that walks the chain of cells, collecting the result.
    typedef struct packed {
        logic               valid;
        logic               found;
        t_status            status;
        logic [IDX_W-1:0]   slot;
        logic [DRAW_W-1:0]  draws;
        logic [VSUM_W-1:0]  verts;
        logic [VCNT_W-1:0]  lo_vcnt;
        logic [VCNT_W-1:0]  hi_vcnt;
    } t_probe;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [DRAW_W-1:0]  draws;
        logic [VSUM_W-1:0]  verts;
        logic [VCNT_W-1:0]  lo_vcnt;
        logic [VCNT_W-1:0]  hi_vcnt;
        logic [SLOT_W-1:0]  used;
        logic [OVF_W-1:0]   ovf;
    } t_result;

endpackage

/* rtl/dsbc_cell.sv */
// ----------------------------------------------------------------------------
// Census bucket cell
// Holds one bucket and its counters. A lookup token passes through each cell,
// which registers it; the cell whose key matches, or the first free cell, updates
// its bucket and writes the bucket contents into the token.
// ----------------------------------------------------------------------------
module dsbc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dsbc_pkg::IDX_W-1:0]     i_index,
    input  logic [dsbc_pkg::CNT_W-1:0]     i_used,
    input  logic [dsbc_pkg::KEY_W-1:0]     i_key,
    input  logic [dsbc_pkg::VCNT_W-1:0]    i_count,
    input  dsbc_pkg::t_probe               i_probe,
    output dsbc_pkg::t_probe               o_probe
);

    logic [dsbc_pkg::KEY_W-1:0]   r_key;
    logic [dsbc_pkg::DRAW_W-1:0]  r_draws;
    logic [dsbc_pkg::VSUM_W-1:0]  r_verts;
    logic [dsbc_pkg::VCNT_W-1:0]  r_min;
    logic [dsbc_pkg::VCNT_W-1:0]  r_max;
    dsbc_pkg::t_probe             r_probe;

    logic [dsbc_pkg::DRAW_W-1:0]  n_draws;
    logic [dsbc_pkg::VSUM_W-1:0]  n_verts;
    logic [dsbc_pkg::VCNT_W-1:0]  n_min;
    logic [dsbc_pkg::VCNT_W-1:0]  n_max;
    dsbc_pkg::t_probe             n_probe;

    logic                         w_live;
    logic                         w_hit;
    logic                         w_alloc;
    logic [dsbc_pkg::VSUM_W:0]    w_sum;

    // Only cells below the fill count hold a bucket; the cell at the fill
    // count is the next free one.
    assign w_live  = i_probe.valid && !i_probe.found;
    assign w_hit   = w_live && (dsbc_pkg::CNT_W'(i_index) < i_used) && (r_key == i_key);
    assign w_alloc = w_live && (dsbc_pkg::CNT_W'(i_index) == i_used);
    assign w_sum   = {1'b0, r_verts} + (dsbc_pkg::VSUM_W + 1)'(i_count);

    always_comb begin
        n_draws = r_draws;
        n_verts = r_verts;
        n_min   = r_min;
        n_max   = r_max;
        n_probe = i_probe;
        if (w_hit) begin
            n_draws = (r_draws == '1) ? r_draws : r_draws + 1'b1;
            n_verts = w_sum[dsbc_pkg::VSUM_W] ? '1 : w_sum[dsbc_pkg::VSUM_W-1:0];
            n_min   = (i_count < r_min) ? i_count : r_min;
            n_max   = (i_count > r_max) ? i_count : r_max;
        end else if (w_alloc) begin
            n_draws = dsbc_pkg::DRAW_W'(1);
            n_verts = dsbc_pkg::VSUM_W'(i_count);
            n_min   = i_count;
            n_max   = i_count;
        end
        if (w_hit || w_alloc) begin
            n_probe.found   = 1'b1;
            n_probe.status  = w_hit ? dsbc_pkg::ST_HIT : dsbc_pkg::ST_NEW;
            n_probe.slot    = i_index;
            n_probe.draws   = n_draws;
            n_probe.verts   = n_verts;
            n_probe.lo_vcnt = n_min;
            n_probe.hi_vcnt = n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_key <= i_key;
        end
        r_draws <= n_draws;
        r_verts <= n_verts;
        r_min   <= n_min;
        r_max   <= n_max;
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

/* rtl/draw_state_bucket_census_unit.sv */
// ----------------------------------------------------------------------------
// Draw state bucket census unit
// Counts draw events per distinct render-state key in a chain of bucket
// cells, with draw count, vertex sum and vertex count range per bucket.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Beat
//  in        sink       i_in_valid / o_in_stall        one draw event
//  out       source     o_out_valid / i_out_stall      one census result
//  cfg       slave      psel, penable, pwrite, pready  census_enable at 0x0
//
//  An enabled draw is accepted in idle and launches a lookup token that walks
//  the chain of bucket cells one cell per cycle; its result is then held
//  pending until the output register is free. A disabled draw goes straight
//  to the pending result. One draw is in work at a time; the next is
//  accepted while a result waits on a stalled output. Reset is synchronous
//  and empties the table.
// ----------------------------------------------------------------------------
module draw_state_bucket_census_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [15:0]                       i_program_id,
    input  logic [15:0]                       i_framebuffer_id,
    input  logic [2:0]                        i_prim_mode,
    input  logic                              i_depth_on,
    input  logic                              i_cull_on,
    input  logic                              i_blend_on,
    input  logic                              i_is_indexed,
    input  logic                              i_uses_vbo,
    input  logic [dsbc_pkg::VCNT_W-1:0]       i_vertex_count,
    input  logic                              i_window_restart,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [dsbc_pkg::SLOT_W-1:0]       o_slot,
    output logic [dsbc_pkg::DRAW_W-1:0]       o_slot_draws,
    output logic [dsbc_pkg::VSUM_W-1:0]       o_slot_vertices,
    output logic [dsbc_pkg::VCNT_W-1:0]       o_slot_min_count,
    output logic [dsbc_pkg::VCNT_W-1:0]       o_slot_max_count,
    output logic [dsbc_pkg::SLOT_W-1:0]       o_buckets_used,
    output logic [dsbc_pkg::OVF_W-1:0]        o_overflow_total,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsbc_pkg::PADDR_W-1:0]      paddr,
    input  logic [dsbc_pkg::PDATA_W-1:0]      pwdata,
    output logic [dsbc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_launch, n_launch;
    logic                           r_enable;
    logic [dsbc_pkg::CNT_W-1:0]     r_used, n_used;
    logic [dsbc_pkg::OVF_W-1:0]     r_ovf, n_ovf;
    logic [dsbc_pkg::KEY_W-1:0]     r_key, n_key;
    logic [dsbc_pkg::VCNT_W-1:0]    r_cnt, n_cnt;
    dsbc_pkg::t_result              r_pend, n_pend;
    dsbc_pkg::t_result              r_out, n_out;
    logic                           r_out_valid, n_out_valid;

    dsbc_pkg::t_probe               w_chain [0:dsbc_pkg::BUCKETS];
    dsbc_pkg::t_probe               w_end;
    logic                           w_out_free;
    logic                           w_cfg_write;
    logic [dsbc_pkg::CNT_W-1:0]     w_used_inc;
    logic [dsbc_pkg::OVF_W-1:0]     w_ovf_inc;

    // ---------------------------------------------------------------- config
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite &&
                         (paddr[dsbc_pkg::PADDR_W-1:2] == dsbc_pkg::REG_ENABLE);
    assign prdata      = (paddr[dsbc_pkg::PADDR_W-1:2] == dsbc_pkg::REG_ENABLE) ?
                         dsbc_pkg::PDATA_W'(r_enable) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (w_cfg_write) begin
            r_enable <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------- chain
    always_comb begin
        w_chain[0]           = '0;
        w_chain[0].valid     = r_launch;
        w_chain[0].found     = 1'b0;
        w_chain[0].status    = dsbc_pkg::ST_HIT;
    end

    for (genvar g = 0; g < dsbc_pkg::BUCKETS; g++) begin : g_cell
        dsbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (dsbc_pkg::IDX_W'(g)),
            .i_used  (r_used),
            .i_key   (r_key),
            .i_count (r_cnt),
            .i_probe (w_chain[g]),
            .o_probe (w_chain[g+1])
        );
    end

    assign w_end      = w_chain[dsbc_pkg::BUCKETS];
    assign w_used_inc = r_used + dsbc_pkg::CNT_W'(w_end.status == dsbc_pkg::ST_NEW);
    assign w_ovf_inc  = (r_ovf == '1) ? r_ovf : r_ovf + 1'b1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state     = r_state;
        n_launch    = 1'b0;
        n_used      = r_used;
        n_ovf       = r_ovf;
        n_key       = r_key;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key = {i_program_id, i_framebuffer_id, i_prim_mode, i_depth_on,
                             i_cull_on, i_blend_on, i_is_indexed, i_uses_vbo};
                    n_cnt = i_vertex_count;
                    if (r_enable) begin
                        // A restart empties the table before the lookup starts.
                        if (i_window_restart) begin
                            n_used = '0;
                            n_ovf  = '0;
                        end
                        n_launch = 1'b1;
                        n_state  = S_WALK;
                    end else begin
                        n_pend        = '0;
                        n_pend.status = dsbc_pkg::ST_OFF;
                        n_pend.used   = dsbc_pkg::SLOT_W'(r_used);
                        n_pend.ovf    = r_ovf;
                        n_state       = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (w_end.valid) begin
                    n_pend = '0;
                    if (w_end.found) begin
                        n_used          = w_used_inc;
                        n_pend.status   = w_end.status;
                        n_pend.slot     = dsbc_pkg::SLOT_W'(w_end.slot);
                        n_pend.draws    = w_end.draws;
                        n_pend.verts    = w_end.verts;
                        n_pend.lo_vcnt  = w_end.lo_vcnt;
                        n_pend.hi_vcnt  = w_end.hi_vcnt;
                        n_pend.used     = dsbc_pkg::SLOT_W'(w_used_inc);
                        n_pend.ovf      = r_ovf;
                    end else begin
                        n_ovf         = w_ovf_inc;
                        n_pend.status = dsbc_pkg::ST_FULL;
                        n_pend.used   = dsbc_pkg::SLOT_W'(r_used);
                        n_pend.ovf    = w_ovf_inc;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_used      <= '0;
            r_ovf       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_used      <= n_used;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_key  <= n_key;
        r_cnt  <= n_cnt;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_slot           = r_out.slot;
    assign o_slot_draws     = r_out.draws;
    assign o_slot_vertices  = r_out.verts;
    assign o_slot_min_count = r_out.lo_vcnt;
    assign o_slot_max_count = r_out.hi_vcnt;
    assign o_buckets_used   = r_out.used;
    assign o_overflow_total = r_out.ovf;

    // ---------------------------------------------------------------- checks
    a_end_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> r_state == S_WALK)
        else $error("lookup token left the chain outside a walk");

    a_miss_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.valid && !w_end.found) |-> r_used == dsbc_pkg::CNT_W'(dsbc_pkg::BUCKETS))
        else $error("lookup missed while a free bucket remained");

    a_new_bumps_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.valid && w_end.found && w_end.status == dsbc_pkg::ST_NEW)
        |=> r_used == dsbc_pkg::CNT_W'($past(r_used) + 1'b1))
        else $error("new bucket did not advance the fill count");

    a_single_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |=> !r_launch && r_state == S_WALK)
        else $error("second lookup launched during a walk");

endmodule

/* test/draw_state_bucket_census_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw state bucket census unit testbench
// Feeds draw events to the census unit and compares every census result,
// field by field, with a software copy of the bucket table.
// A short table of directed draws comes first. It covers the disabled state,
// hits, new buckets, a full table with overflow, restarts and the field
// extremes. Windows of random draws follow. Most windows reuse a small or
// table-filling set of keys; the rest are pure noise. Output stalls and input
// gaps come in random bursts; the enable register is written between phases.
// ----------------------------------------------------------------------------
module draw_state_bucket_census_unit_tb;

    localparam int ITEMS_TOTAL = 1750;
    localparam int CALM_ITEMS  = 200;
    localparam logic [dsbc_pkg::VCNT_W-1:0]  VMAX        = '1;
    localparam logic [dsbc_pkg::PADDR_W-1:0] ENABLE_ADDR = {dsbc_pkg::REG_ENABLE, 2'b00};

    typedef struct packed {
        logic [15:0] program_id;
        logic [15:0] framebuffer_id;
        logic [2:0]  prim_mode;
        logic        depth_on;
        logic        cull_on;
        logic        blend_on;
        logic        is_indexed;
        logic        uses_vbo;
    } t_key;

    typedef struct packed {
        t_key                         key;
        logic [dsbc_pkg::VCNT_W-1:0]  vertex_count;
        logic                         window_restart;
    } t_draw;

    typedef struct {
        bit                           en;
        int                           fill;
        t_key                         key;
        logic [dsbc_pkg::VCNT_W-1:0]  vcnt;
        logic                         restart;
        bit                           typed;
        dsbc_pkg::t_result            want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_draw drv = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dsbc_pkg::PADDR_W-1:0] paddr = '0;
    logic [dsbc_pkg::PDATA_W-1:0] pwdata = '0;

    logic o_in_stall, o_out_valid, pready;
    logic [1:0] o_status;
    logic [dsbc_pkg::SLOT_W-1:0] o_slot, o_buckets_used;
    logic [dsbc_pkg::DRAW_W-1:0] o_slot_draws;
    logic [dsbc_pkg::VSUM_W-1:0] o_slot_vertices;
    logic [dsbc_pkg::VCNT_W-1:0] o_slot_min_count, o_slot_max_count;
    logic [dsbc_pkg::OVF_W-1:0] o_overflow_total;
    logic [dsbc_pkg::PDATA_W-1:0] prdata;

    // Shadow copy of the bucket table and its counters.
    t_key                        key_tab  [dsbc_pkg::BUCKETS];
    logic [dsbc_pkg::DRAW_W-1:0] draw_tab [dsbc_pkg::BUCKETS];
    logic [dsbc_pkg::VSUM_W-1:0] vsum_tab [dsbc_pkg::BUCKETS];
    logic [dsbc_pkg::VCNT_W-1:0] min_tab  [dsbc_pkg::BUCKETS];
    logic [dsbc_pkg::VCNT_W-1:0] max_tab  [dsbc_pkg::BUCKETS];
    int                          used_now = 0;
    logic [dsbc_pkg::OVF_W-1:0]  ovf_now = '0;
    bit                          census_on = 1'b0;

    dsbc_pkg::t_result census_results[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    draw_state_bucket_census_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_program_id     (drv.key.program_id),
        .i_framebuffer_id (drv.key.framebuffer_id),
        .i_prim_mode      (drv.key.prim_mode),
        .i_depth_on       (drv.key.depth_on),
        .i_cull_on        (drv.key.cull_on),
        .i_blend_on       (drv.key.blend_on),
        .i_is_indexed     (drv.key.is_indexed),
        .i_uses_vbo       (drv.key.uses_vbo),
        .i_vertex_count   (drv.vertex_count),
        .i_window_restart (drv.window_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_slot_draws     (o_slot_draws),
        .o_slot_vertices  (o_slot_vertices),
        .o_slot_min_count (o_slot_min_count),
        .o_slot_max_count (o_slot_max_count),
        .o_buckets_used   (o_buckets_used),
        .o_overflow_total (o_overflow_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch %0d at %0t: %s got %0h want %0h",
                 mismatch_count, $realtime, what, got, want);
    endtask

    // Updates the shadow table with one accepted draw and returns its result.
    function automatic dsbc_pkg::t_result census_predict(t_draw d);
        dsbc_pkg::t_result r;
        int i;
        int at;
        logic [dsbc_pkg::VSUM_W:0] sum;
        r = '0;
        if (!census_on) begin
            r.status = dsbc_pkg::ST_OFF;
            r.used   = dsbc_pkg::SLOT_W'(used_now);
            r.ovf    = ovf_now;
            return r;
        end
        if (d.window_restart) begin
            used_now = 0;
            ovf_now  = '0;
        end
        at = -1;
        for (i = 0; i < used_now; i++) begin
            if (at < 0 && key_tab[i] == d.key) at = i;
        end
        if (at >= 0) begin
            if (draw_tab[at] != '1) draw_tab[at] = draw_tab[at] + 1'b1;
            sum = {1'b0, vsum_tab[at]} + (dsbc_pkg::VSUM_W + 1)'(d.vertex_count);
            vsum_tab[at] = sum[dsbc_pkg::VSUM_W] ? '1 : sum[dsbc_pkg::VSUM_W-1:0];
            if (d.vertex_count < min_tab[at]) min_tab[at] = d.vertex_count;
            if (d.vertex_count > max_tab[at]) max_tab[at] = d.vertex_count;
            r.status = dsbc_pkg::ST_HIT;
        end else if (used_now < dsbc_pkg::BUCKETS) begin
            at = used_now;
            used_now++;
            key_tab[at]  = d.key;
            draw_tab[at] = dsbc_pkg::DRAW_W'(1);
            vsum_tab[at] = dsbc_pkg::VSUM_W'(d.vertex_count);
            min_tab[at]  = d.vertex_count;
            max_tab[at]  = d.vertex_count;
            r.status = dsbc_pkg::ST_NEW;
        end else begin
            if (ovf_now != '1) ovf_now = ovf_now + 1'b1;
            r.status = dsbc_pkg::ST_FULL;
        end
        if (r.status != dsbc_pkg::ST_FULL) begin
            r.slot    = dsbc_pkg::SLOT_W'(at);
            r.draws   = draw_tab[at];
            r.verts   = vsum_tab[at];
            r.lo_vcnt = min_tab[at];
            r.hi_vcnt = max_tab[at];
        end
        r.used = dsbc_pkg::SLOT_W'(used_now);
        r.ovf  = ovf_now;
        return r;
    endfunction

    // Result monitor: every accepted beat is matched against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        dsbc_pkg::t_result got;
        dsbc_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{status: dsbc_pkg::t_status'(o_status), slot: o_slot,
                    draws: o_slot_draws, verts: o_slot_vertices,
                    lo_vcnt: o_slot_min_count, hi_vcnt: o_slot_max_count,
                    used: o_buckets_used, ovf: o_overflow_total};
            if (census_results.size() == 0) begin
                report_mismatch("beat with nothing expected, status",
                                64'(got.status), 64'd0);
            end else begin
                want = census_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.slot != want.slot)
                    report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                if (got.draws != want.draws)
                    report_mismatch("slot_draws", 64'(got.draws), 64'(want.draws));
                if (got.verts != want.verts)
                    report_mismatch("slot_vertices", 64'(got.verts), 64'(want.verts));
                if (got.lo_vcnt != want.lo_vcnt)
                    report_mismatch("slot_min_count", 64'(got.lo_vcnt), 64'(want.lo_vcnt));
                if (got.hi_vcnt != want.hi_vcnt)
                    report_mismatch("slot_max_count", 64'(got.hi_vcnt), 64'(want.hi_vcnt));
                if (got.used != want.used)
                    report_mismatch("buckets_used", 64'(got.used), 64'(want.used));
                if (got.ovf != want.ovf)
                    report_mismatch("overflow_total", 64'(got.ovf), 64'(want.ovf));
            end
        end
    end

    // Output backpressure in random bursts, switched off near the end.
    always @(negedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_key mk_key(logic [15:0] prog, logic [15:0] fb, logic [2:0] mode,
                                    logic [4:0] flags);
        return {prog, fb, mode, flags};
    endfunction

    function automatic t_dir_row mk_row(bit en, int fill, t_key k,
                                        logic [dsbc_pkg::VCNT_W-1:0] vc, logic rs,
                                        bit typed, dsbc_pkg::t_result want);
        t_dir_row row;
        row.en = en;
        row.fill = fill;
        row.key = k;
        row.vcnt = vc;
        row.restart = rs;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic t_key rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[39:0];
    endfunction

    function automatic logic [dsbc_pkg::VCNT_W-1:0] rand_vcount();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return VMAX;
            2, 3: return dsbc_pkg::VCNT_W'($urandom_range(0, 1000));
            default: return dsbc_pkg::VCNT_W'($urandom);
        endcase
    endfunction

    task automatic send_draw(t_draw d, bit typed, dsbc_pkg::t_result want);
        int gap;
        dsbc_pkg::t_result p;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        drv <= d;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (census_on) items_sent++;
        p = census_predict(d);
        census_results.push_back(typed ? want : p);
        if (items_sent >= ITEMS_TOTAL - CALM_ITEMS) calm = 1'b1;
    endtask

    // Parks the sender and waits until every expected beat has come back.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (census_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_enable(bit value);
        logic [dsbc_pkg::PDATA_W-1:0] rd;
        drain();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ENABLE_ADDR;
        pwdata <= dsbc_pkg::PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[0] != value) report_mismatch("census_enable readback", 64'(rd), 64'(value));
        census_on = value;
    endtask

    // Random windows: small key sets that hit often, key sets large enough to
    // fill the table and overflow it, and draws with unrelated random keys.
    task automatic run_windows(int target);
        int kind;
        int psize;
        int len;
        int j;
        int bitpos;
        t_key pool[$];
        t_key base;
        logic [39:0] flipped;
        t_draw d;
        while (items_sent < target) begin
            kind = $urandom_range(0, 19);
            psize = 0;
            pool.delete();
            base = rand_key();
            if (kind < 16) begin
                psize = (kind < 12) ? $urandom_range(1, 12) : $urandom_range(97, 110);
                repeat (psize) begin
                    if ($urandom_range(0, 2) == 0) begin
                        flipped = base;
                        bitpos = $urandom_range(0, 39);
                        flipped[bitpos] = ~flipped[bitpos];
                        pool.push_back(flipped);
                    end else begin
                        pool.push_back(rand_key());
                    end
                end
                len = (kind < 12) ? $urandom_range(5, 30) : psize + $urandom_range(10, 40);
            end else begin
                len = $urandom_range(5, 20);
            end
            for (j = 0; j < len && items_sent < target; j++) begin
                if (kind >= 16) begin
                    d.key = rand_key();
                    d.window_restart = ($urandom_range(0, 3) == 0);
                end else begin
                    // Filling windows walk the whole key set once before reusing it.
                    d.key = (kind >= 12 && j < psize) ? pool[j]
                                                      : pool[$urandom_range(0, psize - 1)];
                    d.window_restart = (j == 0) ? ($urandom_range(0, 7) != 0)
                                                : ($urandom_range(0, 39) == 0);
                end
                d.vertex_count = rand_vcount();
                send_draw(d, 1'b0, '0);
            end
            if ($urandom_range(0, 9) == 0) drain();
        end
    endtask

    initial begin
        t_dir_row rows[$];
        t_draw d;
        int j;
        int k;

        rows.push_back(mk_row(1'b0, 0, '1, VMAX, 1'b1, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_OFF, 7'd0, 32'd0, 48'd0, 31'd0, 31'd0,
                                7'd0, 32'd0}));
        rows.push_back(mk_row(1'b0, 0, '0, '0, 1'b0, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_OFF, 7'd0, 32'd0, 48'd0, 31'd0, 31'd0,
                                7'd0, 32'd0}));
        rows.push_back(mk_row(1'b1, 0, '0, '0, 1'b1, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_NEW, 7'd0, 32'd1, 48'd0, 31'd0, 31'd0,
                                7'd1, 32'd0}));
        rows.push_back(mk_row(1'b1, 0, '0, VMAX, 1'b0, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_HIT, 7'd0, 32'd2, 48'h7FFF_FFFF, 31'd0, VMAX,
                                7'd1, 32'd0}));
        rows.push_back(mk_row(1'b1, 0, '0, 31'd5, 1'b0, 1'b0, '0));
        rows.push_back(mk_row(1'b1, 0, '1, VMAX, 1'b0, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_NEW, 7'd1, 32'd1, 48'h7FFF_FFFF, VMAX, VMAX,
                                7'd2, 32'd0}));
        for (k = 1; k < 8; k++)
            rows.push_back(mk_row(1'b1, 0, mk_key(16'h0, 16'h0, k[2:0], 5'b0),
                                  dsbc_pkg::VCNT_W'(k * 3), 1'b0, 1'b0, '0));
        for (k = 0; k < 5; k++)
            rows.push_back(mk_row(1'b1, 0, mk_key(16'h0, 16'h0, 3'd0, 5'(1 << k)),
                                  dsbc_pkg::VCNT_W'(k), 1'b0, 1'b0, '0));
        rows.push_back(mk_row(1'b1, 0, mk_key(16'h8000, 16'h0, 3'd0, 5'b0), 31'd11,
                              1'b0, 1'b0, '0));
        rows.push_back(mk_row(1'b1, 0, mk_key(16'h0, 16'h0001, 3'd0, 5'b0), 31'd12,
                              1'b0, 1'b0, '0));
        // The fill rows load program ids 0 to 95 first, so this key overflows.
        rows.push_back(mk_row(1'b1, dsbc_pkg::BUCKETS,
            mk_key(16'hFFFF, 16'hBEEF, 3'd4, 5'b10101), 31'd9, 1'b0, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_FULL, 7'd0, 32'd0, 48'd0, 31'd0, 31'd0,
                                7'd96, 32'd1}));
        rows.push_back(mk_row(1'b1, 0, mk_key(16'hFFFF, 16'hBEEF, 3'd4, 5'b10101), 31'd9,
                              1'b0, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_FULL, 7'd0, 32'd0, 48'd0, 31'd0, 31'd0,
                                7'd96, 32'd2}));
        rows.push_back(mk_row(1'b1, 0, mk_key(16'd5, 16'hBEEF, 3'd4, 5'b10101), '0,
                              1'b0, 1'b0, '0));
        rows.push_back(mk_row(1'b1, 0, '1, 31'd7, 1'b1, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_NEW, 7'd0, 32'd1, 48'd7, 31'd7, 31'd7,
                                7'd1, 32'd0}));
        rows.push_back(mk_row(1'b0, 0, '1, 31'd3, 1'b1, 1'b1,
            dsbc_pkg::t_result'{dsbc_pkg::ST_OFF, 7'd0, 32'd0, 48'd0, 31'd0, 31'd0,
                                7'd1, 32'd0}));
        rows.push_back(mk_row(1'b1, 0, '1, 31'd1, 1'b0, 1'b0, '0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].en != census_on) set_enable(rows[r].en);
            for (j = 0; j < rows[r].fill; j++) begin
                d.key = rows[r].key;
                d.key.program_id = j[15:0];
                d.vertex_count = dsbc_pkg::VCNT_W'(j);
                d.window_restart = (j == 0);
                send_draw(d, 1'b0, '0);
            end
            d.key = rows[r].key;
            d.vertex_count = rows[r].vcnt;
            d.window_restart = rows[r].restart;
            send_draw(d, rows[r].typed, rows[r].want);
        end

        run_windows(1000);
        set_enable(1'b0);
        repeat (60) begin
            d.key = rand_key();
            d.vertex_count = rand_vcount();
            d.window_restart = 1'($urandom_range(0, 1));
            send_draw(d, 1'b0, '0);
        end
        // The table survives the disabled stretch, so windows may build on it.
        set_enable(1'b1);
        run_windows(ITEMS_TOTAL);

        drain();
        repeat (dsbc_pkg::BUCKETS + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("draw_state_bucket_census_unit_tb: done, clean");
        end else begin
            $display("draw_state_bucket_census_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("draw_state_bucket_census_unit_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
rtl/dsbc_pkg.sv
rtl/dsbc_cell.sv
rtl/draw_state_bucket_census_unit.sv
test/draw_state_bucket_census_unit_tb.sv
